@@ design/nfba_pkg.sv @@
package nfba_pkg;

  localparam int unsigned CELLS  = 256;
  localparam int unsigned CELL_W = $clog2(CELLS);
  localparam int unsigned PTR_W  = $clog2(CELLS + 1);

  typedef enum logic [1:0] {
    REQ_FIND  = 2'd0,
    REQ_PLACE = 2'd1,
    REQ_FREE  = 2'd2
  } req_type_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN_TAIL,
    ST_SCAN_HEAD,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic latch;
    logic start_tail;
    logic start_head;
    logic step;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_find;
    logic len_zero;
    logic ptr_at_end;
    logic ptr_zero;
    logic hit;
    logic last_tail;
    logic last_head;
    logic slot_free;
  } dp_status_t;

endpackage

@@ design/nfba_if.sv @@
interface nfba_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [8:0]  run_length;
  logic [7:0]  offset;
  logic signed [31:0] value;
  logic [7:0]  base_in;

  modport source (output valid, req_type, run_length, offset, value, base_in, input ready);
  modport sink (input valid, req_type, run_length, offset, value, base_in, output ready);
endinterface

interface nfba_rsp_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [7:0]  base_out;
  logic [31:0] base_sum;
  logic [31:0] success_count;
  logic [31:0] failure_count;

  modport source (output valid, ok, base_out, base_sum, success_count, failure_count,
                  input ready);
  modport sink (input valid, ok, base_out, base_sum, success_count, failure_count,
                output ready);
endinterface

@@ design/nfba_ctrl.sv @@
module nfba_ctrl
  import nfba_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (!status_i.is_find || status_i.len_zero) begin
          state_d = ST_FINISH;
        end else if (!status_i.ptr_at_end) begin
          cmd_o.start_tail = 1'b1;
          state_d          = ST_SCAN_TAIL;
        end else if (!status_i.ptr_zero) begin
          cmd_o.start_head = 1'b1;
          state_d          = ST_SCAN_HEAD;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_SCAN_TAIL: begin
        if (status_i.hit) begin
          cmd_o.step = 1'b1;
          state_d    = ST_FINISH;
        end else if (status_i.last_tail) begin
          if (status_i.ptr_zero) begin
            state_d = ST_FINISH;
          end else begin
            cmd_o.start_head = 1'b1;
            state_d          = ST_SCAN_HEAD;
          end
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      ST_SCAN_HEAD: begin
        cmd_o.step = 1'b1;
        if (status_i.hit || status_i.last_head) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status_i.slot_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (state_q == ST_IDLE))
    else $error("ready outside idle");
  a_latch_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.latch |=> (state_q == ST_DISPATCH))
    else $error("latch not followed by dispatch");
  a_finish_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> (state_q == ST_IDLE))
    else $error("finish not followed by idle");
`endif

endmodule

@@ design/nfba_dp.sv @@
module nfba_dp
  import nfba_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  nfba_req_if.sink   req_i,
  nfba_rsp_if.source rsp_o,
  input  ctrl_cmd_t  cmd_i,
  output dp_status_t status_o
);

  logic [1:0]        req_q;
  logic [PTR_W-1:0]  len_q;
  logic [7:0]        off_q;
  logic [31:0]       val_q;
  logic [CELL_W-1:0] bin_q;

  logic [PTR_W-1:0]  idx_q, run_q;
  logic [CELL_W-1:0] base_q;
  logic              found_q;
  logic [PTR_W-1:0]  ptr_q, ptr_d;
  logic [31:0]       total_q, total_d, succ_q, succ_d, fail_q, fail_d;
  logic [CELLS-1:0]  map_q, map_d;
  logic [31:0]       mem [CELLS];

  logic              out_valid_q, out_valid_d;
  logic              out_ok_q;
  logic [7:0]        out_base_q;
  logic [31:0]       out_sum_q, out_succ_q, out_fail_q;

  logic              cell_free, hit, is_find, find_ok;
  logic [PTR_W-1:0]  run_next;
  logic [CELL_W-1:0] base_next, tgt_base;
  logic [CELL_W:0]   tgt;
  logic              tgt_ok, do_mark, do_free, ok_d;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q <= req_i.req_type;
      len_q <= PTR_W'(req_i.run_length);
      off_q <= req_i.offset;
      val_q <= req_i.value;
      bin_q <= CELL_W'(req_i.base_in);
    end
  end

  assign cell_free = !map_q[idx_q[CELL_W-1:0]];
  assign run_next  = cell_free ? run_q + PTR_W'(1) : '0;
  assign hit       = (run_next == len_q);
  assign base_next = CELL_W'(idx_q + PTR_W'(1) - len_q);
  assign is_find   = (req_q == REQ_FIND);
  assign find_ok   = is_find && found_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      run_q   <= '0;
      found_q <= 1'b0;
    end else begin
      if (cmd_i.latch) begin
        found_q <= 1'b0;
      end
      if (cmd_i.start_tail) begin
        idx_q <= ptr_q;
        run_q <= '0;
      end else if (cmd_i.start_head) begin
        idx_q <= '0;
        run_q <= '0;
      end else if (cmd_i.step) begin
        idx_q <= idx_q + PTR_W'(1);
        run_q <= run_next;
        if (hit) begin
          found_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step && hit) begin
      base_q <= base_next;
    end
  end

  assign tgt_base = is_find ? base_q : bin_q;
  assign tgt      = {1'b0, tgt_base} + (CELL_W + 1)'(off_q);
  assign tgt_ok   = (tgt < (CELL_W + 1)'(CELLS));
  assign do_mark  = cmd_i.finish && (find_ok || (req_q == REQ_PLACE)) && tgt_ok;
  assign do_free  = cmd_i.finish && (req_q == REQ_FREE);

  always_comb begin
    map_d = map_q;
    for (int i = 0; i < CELLS; i++) begin
      if (do_free && (PTR_W'(i) >= PTR_W'(bin_q))
          && ((PTR_W'(i) - PTR_W'(bin_q)) < len_q)) begin
        map_d[i] = 1'b0;
      end
    end
    if (do_mark) begin
      map_d[tgt[CELL_W-1:0]] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_mark) begin
      mem[tgt[CELL_W-1:0]] <= val_q;
    end
  end

  always_comb begin
    ptr_d   = ptr_q;
    total_d = total_q;
    succ_d  = succ_q;
    fail_d  = fail_q;
    if (find_ok) begin
      ptr_d   = PTR_W'(base_q) + len_q;
      total_d = total_q + 32'(base_q);
      succ_d  = succ_q + 32'd1;
    end else if (is_find) begin
      fail_d = fail_q + 32'd1;
    end
  end

  assign ok_d        = find_ok || (req_q == REQ_PLACE) || (req_q == REQ_FREE);
  assign out_valid_d = cmd_i.finish ? 1'b1 : (rsp_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q       <= '0;
      ptr_q       <= '0;
      total_q     <= '0;
      succ_q      <= '0;
      fail_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      map_q       <= map_d;
      out_valid_q <= out_valid_d;
      if (cmd_i.finish) begin
        ptr_q   <= ptr_d;
        total_q <= total_d;
        succ_q  <= succ_d;
        fail_q  <= fail_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_ok_q   <= ok_d;
      out_base_q <= 8'(find_ok ? base_q : bin_q);
      out_sum_q  <= total_d;
      out_succ_q <= succ_d;
      out_fail_q <= fail_d;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.ok            = out_ok_q;
  assign rsp_o.base_out      = out_base_q;
  assign rsp_o.base_sum      = out_sum_q;
  assign rsp_o.success_count = out_succ_q;
  assign rsp_o.failure_count = out_fail_q;

  assign status_o.is_find    = is_find;
  assign status_o.len_zero   = (len_q == '0);
  assign status_o.ptr_at_end = (ptr_q == PTR_W'(CELLS));
  assign status_o.ptr_zero   = (ptr_q == '0);
  assign status_o.hit        = hit;
  assign status_o.last_tail  = (idx_q == PTR_W'(CELLS - 1));
  assign status_o.last_head  = (idx_q == ptr_q - PTR_W'(1));
  assign status_o.slot_free  = !out_valid_q || rsp_o.ready;

`ifndef SYNTHESIS
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= PTR_W'(CELLS))
    else $error("resume pointer out of range");
  a_finish_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> (!out_valid_q || rsp_o.ready))
    else $error("result overwrites pending transfer");
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (idx_q < PTR_W'(CELLS)))
    else $error("scan index past last cell");
  a_success_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && find_ok) |=> (succ_q == $past(succ_q) + 32'd1))
    else $error("success count not advanced");
`endif

endmodule

@@ design/next_fit_bitmap_allocator_top.sv @@
// Channel  Dir  Handshake     Payload
// req_i    in   valid/ready   req_type, run_length, offset, value, base_in
// rsp_o    out  valid/ready   ok, base_out, base_sum, success_count, failure_count
//
// Find: idle, dispatch, a scan of up to CELLS cells at one cell a cycle, finish.
// Place, free and unused codes: idle, dispatch, finish.
// Reset clears the bitmap, resume pointer and counters at once; no clearing pass.
// A result register holds the response; the next request is taken while it waits,
// and the closing step holds until that register is free.
module next_fit_bitmap_allocator_top
  import nfba_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  nfba_req_if.sink   req_i,
  nfba_rsp_if.source rsp_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       in_ready;

  assign req_i.ready = in_ready;

  nfba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  nfba_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_i),
    .rsp_o    (rsp_o),
    .cmd_i    (cmd),
    .status_o (status)
  );

endmodule
